### rtl/mk_pkg.sv
// Morse keyer package: shared types, register indexes, sequencer states
// and the Morse glyph table. No dependencies.
package mk_pkg;

    localparam int TICKS_W     = 16;
    localparam int SEG_TICKS_W = 17;
    localparam int CHAR_W      = 8;
    localparam int MAX_SYMS    = 6;
    localparam int SYM_CNT_W   = 3;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_DOT_TICKS  = 1'b0;
    localparam cfg_index_t CFG_DASH_TICKS = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MARK,
        SEQ_SPACE,
        SEQ_CHAR_GAP,
        SEQ_SINGLE
    } seq_state_t;

    // One keying segment as it leaves the block.
    typedef struct packed {
        logic                   key_on;
        logic [SEG_TICKS_W-1:0] segment_ticks;
        logic                   status;
        logic                   last_segment;
    } segment_t;

    // Symbol i of a glyph sits in bit i; a 1 is a dash, a 0 a dot.
    typedef struct packed {
        logic                 known;
        logic [SYM_CNT_W-1:0] len;
        logic [MAX_SYMS-1:0]  bits;
    } glyph_t;

    function automatic glyph_t glyph_lookup(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        glyph_t            g;
        c = code;
        if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
        begin
            c = code ^ 8'h20;
        end
        g = '{known: 1'b1, len: 3'd0, bits: 6'b000000};
        case (c)
            "A": begin g.len = 3'd2; g.bits = 6'b000010; end
            "B": begin g.len = 3'd4; g.bits = 6'b000001; end
            "C": begin g.len = 3'd4; g.bits = 6'b000101; end
            "D": begin g.len = 3'd3; g.bits = 6'b000001; end
            "E": begin g.len = 3'd1; g.bits = 6'b000000; end
            "F": begin g.len = 3'd4; g.bits = 6'b000100; end
            "G": begin g.len = 3'd3; g.bits = 6'b000011; end
            "H": begin g.len = 3'd4; g.bits = 6'b000000; end
            "I": begin g.len = 3'd2; g.bits = 6'b000000; end
            "J": begin g.len = 3'd4; g.bits = 6'b001110; end
            "K": begin g.len = 3'd3; g.bits = 6'b000101; end
            "L": begin g.len = 3'd4; g.bits = 6'b000010; end
            "M": begin g.len = 3'd2; g.bits = 6'b000011; end
            "N": begin g.len = 3'd2; g.bits = 6'b000001; end
            "O": begin g.len = 3'd3; g.bits = 6'b000111; end
            "P": begin g.len = 3'd4; g.bits = 6'b000110; end
            "Q": begin g.len = 3'd4; g.bits = 6'b001011; end
            "R": begin g.len = 3'd3; g.bits = 6'b000010; end
            "S": begin g.len = 3'd3; g.bits = 6'b000000; end
            "T": begin g.len = 3'd1; g.bits = 6'b000001; end
            "U": begin g.len = 3'd3; g.bits = 6'b000100; end
            "V": begin g.len = 3'd4; g.bits = 6'b001000; end
            "W": begin g.len = 3'd3; g.bits = 6'b000110; end
            "X": begin g.len = 3'd4; g.bits = 6'b001001; end
            "Y": begin g.len = 3'd4; g.bits = 6'b001101; end
            "Z": begin g.len = 3'd4; g.bits = 6'b000011; end
            "0": begin g.len = 3'd5; g.bits = 6'b011111; end
            "1": begin g.len = 3'd5; g.bits = 6'b011110; end
            "2": begin g.len = 3'd5; g.bits = 6'b011100; end
            "3": begin g.len = 3'd5; g.bits = 6'b011000; end
            "4": begin g.len = 3'd5; g.bits = 6'b010000; end
            "5": begin g.len = 3'd5; g.bits = 6'b000000; end
            "6": begin g.len = 3'd5; g.bits = 6'b000001; end
            "7": begin g.len = 3'd5; g.bits = 6'b000011; end
            "8": begin g.len = 3'd5; g.bits = 6'b000111; end
            "9": begin g.len = 3'd5; g.bits = 6'b001111; end
            "?": begin g.len = 3'd6; g.bits = 6'b001100; end
            "/": begin g.len = 3'd5; g.bits = 6'b001001; end
            ",": begin g.len = 3'd6; g.bits = 6'b110011; end
            ".": begin g.len = 3'd6; g.bits = 6'b101010; end
            ";": begin g.len = 3'd6; g.bits = 6'b010101; end
            "!": begin g.len = 3'd6; g.bits = 6'b110101; end
            "@": begin g.len = 3'd6; g.bits = 6'b010110; end
            ":": begin g.len = 3'd6; g.bits = 6'b000111; end
            default: g.known = 1'b0;
        endcase
        return g;
    endfunction

endpackage

### rtl/mk_stream_if.sv
// Valid/ready channel interfaces for the Morse keyer: character input
// and segment output. Depends on mk_pkg.
interface mk_char_if;
    logic                      valid;
    logic                      ready;
    logic [mk_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mk_seg_if;
    logic                           valid;
    logic                           ready;
    logic                           key_on;
    logic [mk_pkg::SEG_TICKS_W-1:0] segment_ticks;
    logic                           status;
    logic                           last_segment;

    modport source (output valid, output key_on, output segment_ticks,
                    output status, output last_segment, input ready);
    modport sink   (input valid, input key_on, input segment_ticks,
                    input status, input last_segment, output ready);
endinterface

### rtl/mk_seq.sv
// Segment sequencer: walks one glyph symbol by symbol through a shift
// register and a symbol counter. Depends on mk_pkg.
module mk_seq
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mk_pkg::CHAR_W-1:0]      char_code,
    input  logic [mk_pkg::TICKS_W-1:0]     dot_ticks,
    input  logic [mk_pkg::TICKS_W-1:0]     dash_ticks,
    input  logic                           take,
    output logic                           idle,
    output logic                           seg_valid,
    output mk_pkg::segment_t               seg
);

    mk_pkg::seq_state_t                 state_reg, state_next;
    logic [mk_pkg::MAX_SYMS-1:0]        pat_reg, pat_next;
    logic [mk_pkg::SYM_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [mk_pkg::SEG_TICKS_W-1:0]     single_ticks_reg, single_ticks_next;
    logic                               single_status_reg, single_status_next;
    mk_pkg::glyph_t                     glyph;
    logic [mk_pkg::SEG_TICKS_W-1:0]     dot_ext, dash_ext;

    assign glyph    = mk_pkg::glyph_lookup(char_code);
    assign dot_ext  = {1'b0, dot_ticks};
    assign dash_ext = {1'b0, dash_ticks};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mk_pkg::SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg           <= pat_next;
        cnt_reg           <= cnt_next;
        single_ticks_reg  <= single_ticks_next;
        single_status_reg <= single_status_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        pat_next           = pat_reg;
        cnt_next           = cnt_reg;
        single_ticks_next  = single_ticks_reg;
        single_status_next = single_status_reg;
        idle               = 1'b0;
        seg_valid          = 1'b1;
        seg                = '{key_on: 1'b0, segment_ticks: dot_ext,
                               status: 1'b0, last_segment: 1'b0};
        case (state_reg)
            mk_pkg::SEQ_IDLE:
            begin
                idle      = 1'b1;
                seg_valid = 1'b0;
                if (start)
                begin
                    pat_next = glyph.bits;
                    cnt_next = glyph.len;
                    if (char_code == mk_pkg::CHAR_SPACE)
                    begin
                        single_ticks_next  = {dash_ticks, 1'b0};
                        single_status_next = 1'b0;
                        state_next         = mk_pkg::SEQ_SINGLE;
                    end
                    else if (!glyph.known)
                    begin
                        single_ticks_next  = '0;
                        single_status_next = 1'b1;
                        state_next         = mk_pkg::SEQ_SINGLE;
                    end
                    else
                    begin
                        state_next = mk_pkg::SEQ_MARK;
                    end
                end
            end
            mk_pkg::SEQ_MARK:
            begin
                seg.key_on        = 1'b1;
                seg.segment_ticks = pat_reg[0] ? dash_ext : dot_ext;
                if (take)
                begin
                    state_next = mk_pkg::SEQ_SPACE;
                end
            end
            mk_pkg::SEQ_SPACE:
            begin
                if (take)
                begin
                    pat_next = pat_reg >> 1;
                    cnt_next = cnt_reg - 3'd1;
                    state_next = (cnt_reg == 3'd1) ? mk_pkg::SEQ_CHAR_GAP
                                                   : mk_pkg::SEQ_MARK;
                end
            end
            mk_pkg::SEQ_CHAR_GAP:
            begin
                seg.segment_ticks = dash_ext;
                seg.last_segment  = 1'b1;
                if (take)
                begin
                    state_next = mk_pkg::SEQ_IDLE;
                end
            end
            mk_pkg::SEQ_SINGLE:
            begin
                seg.segment_ticks = single_ticks_reg;
                seg.status        = single_status_reg;
                seg.last_segment  = 1'b1;
                if (take)
                begin
                    state_next = mk_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = mk_pkg::SEQ_IDLE;
            end
        endcase
    end

endmodule

### rtl/mk_out_stage.sv
// Output register for the segment channel: holds one segment until the
// sink takes it. Depends on mk_pkg and mk_stream_if.
module mk_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             seg_valid,
    input  mk_pkg::segment_t seg,
    output logic             take,
    mk_seg_if.source         seg_out
);

    logic             valid_reg, valid_next;
    mk_pkg::segment_t data_reg, data_next;
    logic             slot_free;

    assign slot_free = !valid_reg || seg_out.ready;
    assign take      = seg_valid && slot_free;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take)
        begin
            valid_next = 1'b1;
            data_next  = seg;
        end
        else if (seg_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign seg_out.valid         = valid_reg;
    assign seg_out.key_on        = data_reg.key_on;
    assign seg_out.segment_ticks = data_reg.segment_ticks;
    assign seg_out.status        = data_reg.status;
    assign seg_out.last_segment  = data_reg.last_segment;

endmodule

### rtl/morse_keyer_core.sv
// Morse keyer top level: configuration registers, segment sequencer and
// output register. Depends on mk_pkg, mk_stream_if, mk_seq, mk_out_stage.
//
// The keyer takes one ASCII character per transfer on char_in and sends
// its Morse keying pattern on seg_out as a run of segments, one segment
// per transfer, each a key level and a duration in ticks. A character of
// n symbols gives 2n+1 segments (mark, then symbol gap, for every symbol,
// then one character gap marked last_segment); a space gives a single off
// segment of twice dash_ticks, and any character not in the table gives a
// single zero-length off segment with status set. Lower-case letters are
// sent as upper case. One sequencer walks the symbols, producing at most
// one segment per cycle into the output register; char_in.ready is high
// only while the sequencer is idle, and it rises again as soon as the
// last segment has been loaded, while that segment may still wait in the
// output register. dot_ticks (index 0) and dash_ticks (index 1) reset to
// 125 and 250 and are written through cfg_we/cfg_index/cfg_wdata; write
// them only while no character is in flight.
module morse_keyer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  mk_pkg::cfg_index_t            cfg_index,
    input  logic [mk_pkg::TICKS_W-1:0]    cfg_wdata,
    mk_char_if.sink                       char_in,
    mk_seg_if.source                      seg_out
);

    logic [mk_pkg::TICKS_W-1:0] dot_ticks_reg, dot_ticks_next;
    logic [mk_pkg::TICKS_W-1:0] dash_ticks_reg, dash_ticks_next;
    logic                       seq_idle;
    logic                       seg_valid;
    logic                       seg_take;
    logic                       start;
    mk_pkg::segment_t           seg;

    // Configuration writes take effect at the clock edge of the write.
    always_comb
    begin
        dot_ticks_next  = dot_ticks_reg;
        dash_ticks_next = dash_ticks_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mk_pkg::CFG_DOT_TICKS:  dot_ticks_next  = cfg_wdata;
                mk_pkg::CFG_DASH_TICKS: dash_ticks_next = cfg_wdata;
                default:
                begin
                    dot_ticks_next  = dot_ticks_reg;
                    dash_ticks_next = dash_ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_ticks_reg  <= 16'd125;
            dash_ticks_reg <= 16'd250;
        end
        else
        begin
            dot_ticks_reg  <= dot_ticks_next;
            dash_ticks_reg <= dash_ticks_next;
        end
    end

    // A character is taken only when the sequencer has finished the last one.
    assign char_in.ready = seq_idle;
    assign start         = char_in.valid && seq_idle;

    mk_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .char_code  (char_in.char_code),
        .dot_ticks  (dot_ticks_reg),
        .dash_ticks (dash_ticks_reg),
        .take       (seg_take),
        .idle       (seq_idle),
        .seg_valid  (seg_valid),
        .seg        (seg)
    );

    // The output register decouples the sink: the sequencer advances
    // whenever the register is empty or is being emptied in this cycle.
    mk_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg       (seg),
        .take      (seg_take),
        .seg_out   (seg_out)
    );

endmodule

### rtl/mk_checker.sv
// Port-level checker for the Morse keyer, bound to morse_keyer_core.
// Depends on mk_pkg and the top level's port list.
module mk_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_key_on,
    input logic [mk_pkg::SEG_TICKS_W-1:0] out_ticks,
    input logic                           out_status,
    input logic                           out_last
);

    // Every character yields at least one segment, so the input is not
    // ready in the cycle after a transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("char_in stayed ready after a transfer");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key_on)
            && $stable(out_ticks) && $stable(out_status) && $stable(out_last))
        else $error("segment changed while stalled");

    // An unsupported character gives exactly one empty off segment.
    a_unsupported_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_last && !out_key_on && out_ticks == '0)
        else $error("malformed unsupported-character segment");

    // A mark is always followed by a gap, so it is never the last segment.
    a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_key_on |-> !out_last && !out_status)
        else $error("key-down segment flagged last or unsupported");

endmodule

bind morse_keyer_core mk_checker u_mk_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (char_in.valid),
    .in_ready   (char_in.ready),
    .out_valid  (seg_out.valid),
    .out_ready  (seg_out.ready),
    .out_key_on (seg_out.key_on),
    .out_ticks  (seg_out.segment_ticks),
    .out_status (seg_out.status),
    .out_last   (seg_out.last_segment)
);
